// ===== hw/rtl/bbd_pkg.sv =====
// Shared types, constants and helpers of the bimedian Bayer demosaic block.
`default_nettype none
package bbd_pkg;

  localparam int BBD_MAX_WIDTH = 4096;
  localparam int BBD_MID_DEPTH = 4;
  localparam int BBD_OUT_DEPTH = 4;

  localparam int BBD_SAMPLE_W  = 16;
  localparam int BBD_PATTERN_W = 2;
  localparam int BBD_WIDTH_W   = 13;
  localparam int BBD_HEIGHT_W  = 16;
  localparam int BBD_CHAN_W    = 8;
  localparam int BBD_INDEX_W   = 2;

  // configuration register indexes
  localparam logic [BBD_INDEX_W-1:0] BBD_REG_PATTERN = 2'd0;
  localparam logic [BBD_INDEX_W-1:0] BBD_REG_WIDTH   = 2'd1;
  localparam logic [BBD_INDEX_W-1:0] BBD_REG_HEIGHT  = 2'd2;

  localparam logic [BBD_PATTERN_W-1:0] BBD_PATTERN_RST = 2'd0;
  localparam logic [BBD_WIDTH_W-1:0]   BBD_WIDTH_RST   = 13'd4096;
  localparam logic [BBD_HEIGHT_W-1:0]  BBD_HEIGHT_RST  = 16'd3;

  // one classified window, front to back
  typedef struct packed {
    logic [BBD_SAMPLE_W-1:0] nw;
    logic [BBD_SAMPLE_W-1:0] n;
    logic [BBD_SAMPLE_W-1:0] ne;
    logic [BBD_SAMPLE_W-1:0] wv;
    logic [BBD_SAMPLE_W-1:0] ce;
    logic [BBD_SAMPLE_W-1:0] ev;
    logic [BBD_SAMPLE_W-1:0] sw;
    logic [BBD_SAMPLE_W-1:0] so;
    logic [BBD_SAMPLE_W-1:0] se;
    logic                    even_y;
    logic                    odd_x;
    logic                    row_done;
    logic                    frame_done;
  } bbd_item_t;

  // one finished pixel
  typedef struct packed {
    logic [BBD_CHAN_W-1:0] red;
    logic [BBD_CHAN_W-1:0] green;
    logic [BBD_CHAN_W-1:0] blue;
    logic                  row_done;
    logic                  frame_done;
  } bbd_pix_t;

  function automatic logic [BBD_CHAN_W-1:0] bbd_sat8(input logic [12:0] v);
    bbd_sat8 = (v > 13'd255) ? 8'd255 : v[BBD_CHAN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bbd_fifo.sv =====
// Small flop-based queue with an occupancy count; depth is a power of two.
`default_nettype none
module bbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           pop_data,
  output logic                            empty,
  output logic      [$clog2(DEPTH):0]     count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bbd_front.sv =====
// Front end: config registers, raster counters, line stores, 3x3 window, site classing.
`default_nettype none
module bbd_front
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH = BBD_MAX_WIDTH,
  parameter int MID_DEPTH = BBD_MID_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [BBD_INDEX_W-1:0]       cfg_index,
  input  wire logic [BBD_HEIGHT_W-1:0]      cfg_data,
  input  wire logic                         in_push,
  input  wire logic [BBD_SAMPLE_W-1:0]      in_raw_sample,
  output logic                              in_full,
  input  wire logic [$clog2(MID_DEPTH):0]   mid_count,
  output logic                              mid_push,
  output bbd_item_t                         mid_item
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CW   = AW + 1;
  localparam int LW   = (CW > BBD_WIDTH_W) ? CW : BBD_WIDTH_W;
  localparam int CNTW = $clog2(MID_DEPTH) + 1;

  logic [BBD_PATTERN_W-1:0] cfg_pattern_r;
  logic [BBD_WIDTH_W-1:0]   cfg_width_r;
  logic [BBD_HEIGHT_W-1:0]  cfg_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pattern_r <= BBD_PATTERN_RST;
      cfg_width_r   <= BBD_WIDTH_RST;
      cfg_height_r  <= BBD_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        BBD_REG_PATTERN: cfg_pattern_r <= cfg_data[BBD_PATTERN_W-1:0];
        BBD_REG_WIDTH:   cfg_width_r   <= cfg_data[BBD_WIDTH_W-1:0];
        BBD_REG_HEIGHT:  cfg_height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [LW-1:0]           width_ext;
  logic [LW-1:0]           w_eff_l;
  logic [CW-1:0]           w_eff;
  logic [CW-1:0]           w_last;
  logic [BBD_HEIGHT_W-1:0] h_eff;
  logic [BBD_HEIGHT_W-1:0] h_last;

  assign width_ext = LW'(cfg_width_r);
  assign w_eff_l   = (width_ext < LW'(3))         ? LW'(3) :
                     (width_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : width_ext;
  assign w_eff     = w_eff_l[CW-1:0];
  assign w_last    = w_eff - CW'(1);
  assign h_eff     = (cfg_height_r < BBD_HEIGHT_W'(3)) ? BBD_HEIGHT_W'(3) : cfg_height_r;
  assign h_last    = h_eff - BBD_HEIGHT_W'(1);

  // raster position of the incoming sample
  logic [AW-1:0]           col_r, col_nxt, col_cur;
  logic [BBD_HEIGHT_W-1:0] row_r, row_nxt, row_cur;
  logic                    col_end, row_end, accept;

  assign accept  = in_push && !in_full;
  assign col_cur = ({1'b0, col_r} >= w_eff) ? w_last[AW-1:0] : col_r;
  assign row_cur = (row_r >= h_eff) ? h_last : row_r;
  assign col_end = ({1'b0, col_cur} == w_last);
  assign row_end = (row_cur == h_last);

  always_comb begin
    col_nxt = col_cur + AW'(1);
    row_nxt = row_cur;
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_cur + BBD_HEIGHT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // read stage: line stores are read at the sample's column
  logic                    rd_valid_r;
  logic [BBD_SAMPLE_W-1:0] rd_sample_r;
  logic [AW-1:0]           rd_addr_r;
  logic                    rd_produce_r;
  logic                    rd_even_y_r, rd_odd_x_r, rd_row_done_r, rd_frame_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_sample_r     <= in_raw_sample;
      rd_addr_r       <= col_cur;
      rd_produce_r    <= (row_cur >= BBD_HEIGHT_W'(2)) && (col_cur >= AW'(2));
      rd_even_y_r     <= row_cur[0] ^ cfg_pattern_r[0];
      rd_odd_x_r      <= ~(col_cur[0] ^ cfg_pattern_r[1]);
      rd_row_done_r   <= col_end;
      rd_frame_done_r <= col_end && row_end;
    end
  end

  logic [BBD_SAMPLE_W-1:0] up_rdata, mid_rdata;

  // upper row takes the old middle row, middle row takes the new sample
  bbd_ram #(.WIDTH(BBD_SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (rd_valid_r),
    .waddr (rd_addr_r),
    .wdata (mid_rdata),
    .raddr (col_cur),
    .rdata (up_rdata)
  );

  bbd_ram #(.WIDTH(BBD_SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (rd_valid_r),
    .waddr (rd_addr_r),
    .wdata (rd_sample_r),
    .raddr (col_cur),
    .rdata (mid_rdata)
  );

  // 3x3 window, [row][col], right column is newest
  logic [BBD_SAMPLE_W-1:0] win_r   [3][3];
  logic [BBD_SAMPLE_W-1:0] win_nxt [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = up_rdata;
    win_nxt[1][2] = mid_rdata;
    win_nxt[2][2] = rd_sample_r;
  end

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= win_nxt[i][j];
        end
      end
    end
  end

  assign mid_push            = rd_valid_r && rd_produce_r;
  assign mid_item.nw         = win_nxt[0][0];
  assign mid_item.n          = win_nxt[0][1];
  assign mid_item.ne         = win_nxt[0][2];
  assign mid_item.wv         = win_nxt[1][0];
  assign mid_item.ce         = win_nxt[1][1];
  assign mid_item.ev         = win_nxt[1][2];
  assign mid_item.sw         = win_nxt[2][0];
  assign mid_item.so         = win_nxt[2][1];
  assign mid_item.se         = win_nxt[2][2];
  assign mid_item.even_y     = rd_even_y_r;
  assign mid_item.odd_x      = rd_odd_x_r;
  assign mid_item.row_done   = rd_row_done_r;
  assign mid_item.frame_done = rd_frame_done_r;

  // reserve a queue slot for the window still in the read stage
  assign in_full = (CNTW'(mid_count) + CNTW'(mid_push)) >= CNTW'(MID_DEPTH);

endmodule
`default_nettype wire

// ===== hw/rtl/bbd_back.sv =====
// Back end: median-of-four and pair averages, channel selection, saturation.
`default_nettype none
module bbd_back
  import bbd_pkg::*;
#(
  parameter int OUT_DEPTH = BBD_OUT_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         mid_empty,
  input  wire bbd_item_t                    mid_item,
  output logic                              mid_pop,
  input  wire logic [$clog2(OUT_DEPTH):0]   out_count,
  output logic                              out_push,
  output bbd_pix_t                          out_pix
);

  localparam int CNTW = $clog2(OUT_DEPTH) + 1;

  typedef struct packed {
    logic [17:0] sum;
    logic [15:0] lo;
    logic [15:0] hi;
  } med_t;

  function automatic med_t med_prep(input logic [15:0] a, input logic [15:0] b,
                                    input logic [15:0] c, input logic [15:0] d);
    logic [15:0] lo_ab, lo_cd, hi_ab, hi_cd;
    med_t        m;
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    lo_cd = (c < d) ? c : d;
    hi_cd = (c < d) ? d : c;
    m.lo  = (lo_ab < lo_cd) ? lo_ab : lo_cd;
    m.hi  = (hi_ab > hi_cd) ? hi_ab : hi_cd;
    m.sum = 18'(a) + 18'(b) + 18'(c) + 18'(d);
    med_prep = m;
  endfunction

  // stage 1: sums and extremes
  logic        b1_valid_r;
  med_t        diag_r, cross_r;
  logic [16:0] pair_h_r, pair_v_r;
  logic [15:0] ce_r;
  logic        even_y_r, odd_x_r, row_done_r, frame_done_r;

  assign mid_pop = !mid_empty &&
                   ((CNTW'(out_count) + CNTW'(b1_valid_r)) < CNTW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else begin
      b1_valid_r <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      diag_r       <= med_prep(mid_item.nw, mid_item.ne, mid_item.sw, mid_item.se);
      cross_r      <= med_prep(mid_item.n, mid_item.wv, mid_item.ev, mid_item.so);
      pair_h_r     <= 17'(mid_item.wv) + 17'(mid_item.ev);
      pair_v_r     <= 17'(mid_item.n) + 17'(mid_item.so);
      ce_r         <= mid_item.ce;
      even_y_r     <= mid_item.even_y;
      odd_x_r      <= mid_item.odd_x;
      row_done_r   <= mid_item.row_done;
      frame_done_r <= mid_item.frame_done;
    end
  end

  // stage 2: drop extremes, scale, saturate, select per site
  logic [17:0]           diag_mid, cross_mid;
  logic [BBD_CHAN_W-1:0] med_d, med_c, pair_h, pair_v, native;

  assign diag_mid  = diag_r.sum - 18'(diag_r.lo) - 18'(diag_r.hi);
  assign cross_mid = cross_r.sum - 18'(cross_r.lo) - 18'(cross_r.hi);
  assign med_d     = bbd_sat8(diag_mid[17:5]);
  assign med_c     = bbd_sat8(cross_mid[17:5]);
  assign pair_h    = bbd_sat8(13'(pair_h_r[16:5]));
  assign pair_v    = bbd_sat8(13'(pair_v_r[16:5]));
  assign native    = bbd_sat8(13'(ce_r[15:4]));

  always_comb begin
    case ({even_y_r, odd_x_r})
      2'b11: begin
        out_pix.blue  = pair_h;
        out_pix.green = native;
        out_pix.red   = pair_v;
      end
      2'b10: begin
        out_pix.blue  = native;
        out_pix.green = med_c;
        out_pix.red   = med_d;
      end
      2'b01: begin
        out_pix.blue  = med_d;
        out_pix.green = med_c;
        out_pix.red   = native;
      end
      default: begin
        out_pix.blue  = pair_v;
        out_pix.green = native;
        out_pix.red   = pair_h;
      end
    endcase
    out_pix.row_done   = row_done_r;
    out_pix.frame_done = frame_done_r;
  end

  assign out_push = b1_valid_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bayer_bimedian_demosaic.sv =====
// Top level of the streaming 3x3 bimedian Bayer demosaic.
//
// Channel | Ports                                        | Handshake
// --------+----------------------------------------------+--------------------------
// in      | in_raw_sample[15:0]                          | push/full, taken on
//         |                                              | in_push & !in_full
// out     | out_red_out, out_green_out, out_blue_out,    | empty/pop, taken on
//         | out_row_done, out_frame_done                 | out_pop & !out_empty
// cfg     | cfg_we, cfg_index[1:0], cfg_data[15:0]       | write on cfg_we, no wait
//
// One raw sample per cycle while the middle queue has room. A sample is read
// against both line stores at its column (registered read), enters the 3x3
// window from the read stage, and an interior window reaches the result queue
// through the read stage, the middle queue and the sort/sum stage; scaling and
// selection feed the result queue from that stage directly.
// Border samples shift the window and update the line stores but give no result.
// Reset (synchronous, active low) clears counters, queues and config registers;
// line store contents stay undefined until a row has passed over them.
// The front stalls only when the middle queue has no room; the back stalls only
// when the result queue fills, so either side can stall without losing a
// transaction.
`default_nettype none
module bayer_bimedian_demosaic
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH = BBD_MAX_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [BBD_INDEX_W-1:0]    cfg_index,
  input  wire logic [BBD_HEIGHT_W-1:0]   cfg_data,
  input  wire logic                      in_push,
  input  wire logic [BBD_SAMPLE_W-1:0]   in_raw_sample,
  output logic                           in_full,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic      [BBD_CHAN_W-1:0]     out_red_out,
  output logic      [BBD_CHAN_W-1:0]     out_green_out,
  output logic      [BBD_CHAN_W-1:0]     out_blue_out,
  output logic                           out_row_done,
  output logic                           out_frame_done
);

  localparam int MID_CW = $clog2(BBD_MID_DEPTH) + 1;
  localparam int OUT_CW = $clog2(BBD_OUT_DEPTH) + 1;

  // front -> middle queue
  logic              mid_push;
  bbd_item_t         mid_push_item;
  logic [MID_CW-1:0] mid_count;

  // middle queue -> back
  logic              mid_pop;
  logic              mid_empty;
  bbd_item_t         mid_head;

  // back -> result queue
  logic              res_push;
  bbd_pix_t          res_push_pix;
  bbd_pix_t          res_head;
  logic [OUT_CW-1:0] res_count;

  bbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MID_DEPTH (BBD_MID_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_raw_sample (in_raw_sample),
    .in_full       (in_full),
    .mid_count     (mid_count),
    .mid_push      (mid_push),
    .mid_item      (mid_push_item)
  );

  // classified windows waiting for the arithmetic
  bbd_fifo #(
    .WIDTH ($bits(bbd_item_t)),
    .DEPTH (BBD_MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_push_item),
    .pop       (mid_pop),
    .pop_data  (mid_head),
    .empty     (mid_empty),
    .count     (mid_count)
  );

  bbd_back #(
    .OUT_DEPTH (BBD_OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_head),
    .mid_pop   (mid_pop),
    .out_count (res_count),
    .out_push  (res_push),
    .out_pix   (res_push_pix)
  );

  // finished pixels, oldest on the ports
  bbd_fifo #(
    .WIDTH ($bits(bbd_pix_t)),
    .DEPTH (BBD_OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_push_pix),
    .pop       (out_pop && !out_empty),
    .pop_data  (res_head),
    .empty     (out_empty),
    .count     (res_count)
  );

  assign out_red_out    = res_head.red;
  assign out_green_out  = res_head.green;
  assign out_blue_out   = res_head.blue;
  assign out_row_done   = res_head.row_done;
  assign out_frame_done = res_head.frame_done;

endmodule
`default_nettype wire
